@@ rtl/upg_pkg.sv @@
package upg_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int ATAN_COUNT = 24;
  localparam int AIDX_W = 5;
  localparam int XW = 50;
  localparam int ZW = 33;
  localparam int ACC_W = 66;
  localparam int SEL_W = 31;

  localparam logic [23:0] GAIN_Q24 = 24'd10188014;

  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_GOAL = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [1:0] REG_MAX_TURN = 2'd0;
  localparam logic [1:0] REG_STEP_SPEED = 2'd1;
  localparam logic [1:0] REG_ARRIVE_TOL = 2'd2;

  localparam logic [14:0] MAX_TURN_RST = 15'd2086;
  localparam logic [30:0] STEP_SPEED_RST = 31'd65536;
  localparam logic [30:0] ARRIVE_TOL_RST = 31'd6554;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] turn;
    logic signed [31:0] advance;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic [47:0]        travelled;
    logic               reached;
  } out_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_angle(input logic [AIDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/unicycle_pose_go_to_goal.sv @@
// channel | dir | handshake              | payload
// in      | in  | in_valid / in_ready     | in_data  (upg_pkg::in_t)
// out     | out | out_valid / out_ready   | out_data (upg_pkg::out_t)
// apb     | in  | psel penable pwrite     | paddr pwdata / prdata
// Manual move: 31-step serial multiply by the CORDIC gain, then N rotation
// iterations, N = CORDIC_ITERATIONS. Goal step: vectoring, range multiply,
// move, serial sum of squares for the arrival test; no sum of squares when
// the new pose is outside the tolerance box, and no vectoring or range
// multiply when the goal equals the pose. Reset and unused: no arithmetic.
// Synchronous reset clears pose, distance and registers to their defaults.
// A result waits in the output register; a new transaction is taken meanwhile.
module unicycle_pose_go_to_goal #(
  parameter int CORDIC_ITERATIONS = upg_pkg::CORDIC_ITER_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  upg_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output upg_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import upg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_VEC   = 9'b000000010,
    S_RNG   = 9'b000000100,
    S_STEER = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_ROT   = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_SQR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [14:0] max_turn;
  logic [30:0] step_speed;
  logic [30:0] arrive_tolerance;

  logic signed [31:0] pose_x, pose_y;
  logic [15:0]        pose_heading;
  logic [47:0]        distance_sum;

  logic [1:0]         cmd;
  logic signed [31:0] adv, gx, gy;
  logic [15:0]        bearing;
  logic [35:0]        range;
  logic               reached;

  logic                 c_start, c_vec, c_done;
  logic signed [XW-1:0] c_x0, c_y0, c_x, c_y;
  logic signed [ZW-1:0] c_z0, c_z;

  logic                    m_start, m_done;
  logic signed [XW-1:0]    m_a, m_b, m_c;
  logic [SEL_W-1:0]        s_a, s_b, s_c;
  logic signed [ACC_W-1:0] m_acc;

  logic in_acc, wr;
  logic signed [32:0] ex_in, ey_in, ex_p, ey_p;
  logic [32:0]        ax, ay;
  logic               near_goal;
  logic signed [16:0] diff, lim;
  logic [35:0]        step;
  logic signed [XW-1:0] xa;
  logic signed [ZW-1:0] zh;
  logic signed [XW-1:0] rx, ry;
  logic signed [34:0] nx, ny;
  logic [31:0]        aadv;
  logic [48:0]        dsum;
  logic signed [ACC_W-1:0] rsum;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign in_acc = in_valid && in_ready;

  always_comb begin
    case (paddr[3:2])
      REG_MAX_TURN:   prdata = {17'd0, max_turn};
      REG_STEP_SPEED: prdata = {1'b0, step_speed};
      REG_ARRIVE_TOL: prdata = {1'b0, arrive_tolerance};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    ex_in = {in_data.goal_x[31], in_data.goal_x} - {pose_x[31], pose_x};
    ey_in = {in_data.goal_y[31], in_data.goal_y} - {pose_y[31], pose_y};
    ex_p = {gx[31], gx} - {pose_x[31], pose_x};
    ey_p = {gy[31], gy} - {pose_y[31], pose_y};
    ax = ex_p[32] ? 33'(-ex_p) : 33'(ex_p);
    ay = ey_p[32] ? 33'(-ey_p) : 33'(ey_p);
    near_goal = (ax <= {2'b0, arrive_tolerance}) && (ay <= {2'b0, arrive_tolerance});

    diff = signed'({1'b0, bearing - pose_heading});
    if (diff[15]) diff = diff - 17'sd65536;
    lim = signed'({2'b0, max_turn});
    if (diff > lim) diff = lim;
    if (diff < -lim) diff = -lim;
    step = (range < {5'd0, step_speed}) ? range : {5'd0, step_speed};

    xa = m_acc[XW+7:8];
    zh = ZW'(signed'({pose_heading, 16'd0}));

    rx = c_x + XW'(32768);
    ry = c_y + XW'(32768);
    nx = 35'(pose_x) + 35'(signed'(rx[XW-1:16]));
    ny = 35'(pose_y) + 35'(signed'(ry[XW-1:16]));
    aadv = adv[31] ? 32'(-adv) : 32'(adv);
    dsum = {1'b0, distance_sum} + {17'd0, aadv};
    rsum = m_acc + ACC_W'(64'sd536870912);
  end

  always_comb begin
    c_start = 1'b0;
    c_vec = 1'b0;
    c_x0 = '0;
    c_y0 = '0;
    c_z0 = '0;
    m_start = 1'b0;
    m_a = '0;
    m_b = '0;
    m_c = '0;
    s_a = '0;
    s_b = '0;
    s_c = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_data.command == CMD_MOVE) begin
          m_start = 1'b1;
          m_a = XW'(in_data.advance);
          s_a = SEL_W'(GAIN_Q24);
        end
        if (in_acc && in_data.command == CMD_GOAL && (ex_in != 0 || ey_in != 0)) begin
          c_start = 1'b1;
          c_vec = 1'b1;
          c_x0 = XW'(ex_in) <<< 6;
          c_y0 = XW'(ey_in) <<< 6;
          if (ex_in[32]) begin
            c_x0 = -c_x0;
            c_y0 = -c_y0;
            c_z0 = ZW'(33'h0_8000_0000);
          end
        end
      end
      S_VEC: begin
        if (c_done) begin
          m_start = 1'b1;
          m_a = c_x;
          s_a = SEL_W'(GAIN_Q24);
        end
      end
      S_STEER: begin
        m_start = 1'b1;
        m_a = XW'(signed'(step));
        s_a = SEL_W'(GAIN_Q24);
      end
      S_MUL: begin
        if (m_done) begin
          c_start = 1'b1;
          c_x0 = xa;
          c_z0 = zh;
          if (zh > 33'sd1073741824) begin
            c_z0 = zh - 33'sd2147483648;
            c_x0 = -xa;
          end else if (zh < -33'sd1073741824) begin
            c_z0 = zh + 33'sd2147483648;
            c_x0 = -xa;
          end
        end
      end
      S_CHK: begin
        if (near_goal) begin
          m_start = 1'b1;
          m_a = XW'(ax);
          m_b = XW'(ay);
          m_c = XW'({1'b0, arrive_tolerance});
          s_a = ax[SEL_W-1:0];
          s_b = ay[SEL_W-1:0];
          s_c = arrive_tolerance;
        end
      end
      S_RNG, S_ROT, S_SQR, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_turn <= MAX_TURN_RST;
      step_speed <= STEP_SPEED_RST;
      arrive_tolerance <= ARRIVE_TOL_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_MAX_TURN:   max_turn <= pwdata[14:0];
        REG_STEP_SPEED: step_speed <= pwdata[30:0];
        REG_ARRIVE_TOL: arrive_tolerance <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pose_x <= '0;
      pose_y <= '0;
      pose_heading <= '0;
      distance_sum <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd <= in_data.command;
            gx <= in_data.goal_x;
            gy <= in_data.goal_y;
            adv <= in_data.advance;
            reached <= 1'b0;
            case (in_data.command)
              CMD_MOVE: begin
                pose_heading <= pose_heading + in_data.turn;
                state <= S_MUL;
              end
              CMD_GOAL: begin
                if (ex_in != 0 || ey_in != 0) begin
                  state <= S_VEC;
                end else begin
                  range <= '0;
                  bearing <= '0;
                  state <= S_STEER;
                end
              end
              CMD_RESET: begin
                pose_x <= '0;
                pose_y <= '0;
                pose_heading <= '0;
                distance_sum <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_VEC: if (c_done) state <= S_RNG;
        S_RNG: begin
          if (m_done) begin
            range <= rsum[ACC_W-1:30];
            bearing <= c_z[31:16] + 16'(c_z[15]);
            state <= S_STEER;
          end
        end
        S_STEER: begin
          pose_heading <= pose_heading + diff[15:0];
          adv <= step[31:0];
          state <= S_MUL;
        end
        S_MUL: if (m_done) state <= S_ROT;
        S_ROT: begin
          if (c_done) begin
            if (nx > 35'sd2147483647) pose_x <= 32'sh7FFFFFFF;
            else if (nx < -35'sd2147483648) pose_x <= 32'sh80000000;
            else pose_x <= nx[31:0];
            if (ny > 35'sd2147483647) pose_y <= 32'sh7FFFFFFF;
            else if (ny < -35'sd2147483648) pose_y <= 32'sh80000000;
            else pose_y <= ny[31:0];
            distance_sum <= dsum[48] ? 48'hFFFF_FFFF_FFFF : dsum[47:0];
            state <= (cmd == CMD_GOAL) ? S_CHK : S_DONE;
          end
        end
        S_CHK: state <= near_goal ? S_SQR : S_DONE;
        S_SQR: begin
          if (m_done) begin
            reached <= m_acc[ACC_W-1] || (m_acc == '0);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.pos_x <= pose_x;
            out_data.pos_y <= pose_y;
            out_data.heading <= pose_heading;
            out_data.travelled <= distance_sum;
            out_data.reached <= reached;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  upg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .start     (c_start),
    .vectoring (c_vec),
    .x0        (c_x0),
    .y0        (c_y0),
    .z0        (c_z0),
    .done      (c_done),
    .x         (c_x),
    .y         (c_y),
    .z         (c_z)
  );

  upg_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (m_start),
    .ma    (m_a),
    .mb    (m_b),
    .mc    (m_c),
    .sa    (s_a),
    .sb    (s_b),
    .sc    (s_c),
    .done  (m_done),
    .acc   (m_acc)
  );

endmodule

@@ rtl/upg_cordic.sv @@
module upg_cordic #(
  parameter int ITER = upg_pkg::CORDIC_ITER_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            vectoring,
  input  logic signed [upg_pkg::XW-1:0]   x0,
  input  logic signed [upg_pkg::XW-1:0]   y0,
  input  logic signed [upg_pkg::ZW-1:0]   z0,
  output logic                            done,
  output logic signed [upg_pkg::XW-1:0]   x,
  output logic signed [upg_pkg::XW-1:0]   y,
  output logic signed [upg_pkg::ZW-1:0]   z
);
  import upg_pkg::*;

  logic              run;
  logic              vec;
  logic [AIDX_W-1:0] cnt;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic              ccw;

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = signed'({1'b0, atan_angle(cnt)});
    ccw = vec ? !(y > 0) : !z[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        vec <= vectoring;
        x <= x0;
        y <= y0;
        z <= z0;
      end else if (run) begin
        if (ccw) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        if (cnt == AIDX_W'(ITER - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

@@ rtl/upg_mac.sv @@
module upg_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [upg_pkg::XW-1:0]      ma,
  input  logic signed [upg_pkg::XW-1:0]      mb,
  input  logic signed [upg_pkg::XW-1:0]      mc,
  input  logic [upg_pkg::SEL_W-1:0]          sa,
  input  logic [upg_pkg::SEL_W-1:0]          sb,
  input  logic [upg_pkg::SEL_W-1:0]          sc,
  output logic                               done,
  output logic signed [upg_pkg::ACC_W-1:0]   acc
);
  import upg_pkg::*;

  // acc = sum over bits, MSB first, of a*sa + b*sb - c*sc
  logic                 run;
  logic [AIDX_W-1:0]    cnt;
  logic signed [XW-1:0] ra, rb, rc;
  logic [SEL_W-1:0]     sha, shb, shc;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    term = '0;
    if (sha[SEL_W-1]) term = term + ACC_W'(ra);
    if (shb[SEL_W-1]) term = term + ACC_W'(rb);
    if (shc[SEL_W-1]) term = term - ACC_W'(rc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        acc <= '0;
        ra <= ma;
        rb <= mb;
        rc <= mc;
        sha <= sa;
        shb <= sb;
        shc <= sc;
      end else if (run) begin
        acc <= (acc <<< 1) + term;
        sha <= sha << 1;
        shb <= shb << 1;
        shc <= shc << 1;
        if (cnt == AIDX_W'(SEL_W - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

@@ rtl/upg_checker.sv @@
module upg_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input upg_pkg::out_t out_data,
  input logic          pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind unicycle_pose_go_to_goal upg_checker u_upg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

@@ tb/pose_checker.sv @@
module pose_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  upg_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  upg_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output int            fail_count,
  output int            pending,
  output int            goal_count,
  output int            reached_count
);
  import upg_pkg::*;

  localparam longint GAIN = 10188014;
  localparam longint POS_HI = 64'sd2147483647;
  localparam longint POS_LO = -64'sd2147483648;
  localparam longint DIST_SAT = 64'hFFFF_FFFF_FFFF;

  longint angle_tab [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  longint cur_x, cur_y, cur_dist;
  logic [15:0] cur_head;
  logic [14:0] lim_turn;
  logic [30:0] lim_speed, tol_dist;
  out_t expected_pose [$];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip_pos(longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic void rotate_advance(logic [15:0] dturn, longint adv);
    longint x, y, z, nx;
    logic [31:0] a32;
    cur_head = cur_head + dturn;
    a32 = {cur_head, 16'h0};
    z = longint'($signed(a32));
    x = fshr(adv * GAIN, 8);
    y = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; x = -x;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; x = -x;
    end
    for (int i = 0; i < CORDIC_ITER_DEF; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); y = y + fshr(x, i); z -= angle_tab[i];
      end else begin
        nx = x + fshr(y, i); y = y - fshr(x, i); z += angle_tab[i];
      end
      x = nx;
    end
    cur_x = clip_pos(cur_x + fshr(x + 32768, 16));
    cur_y = clip_pos(cur_y + fshr(y + 32768, 16));
    cur_dist += (adv < 0) ? -adv : adv;
    if (cur_dist > DIST_SAT) cur_dist = DIST_SAT;
  endfunction

  function automatic logic seek_goal(longint gx, longint gy);
    longint ex, ey, x, y, nx, diff, lim, stride, rng, ax, ay, tol;
    logic [31:0] z;
    logic [15:0] bearing;
    ex = gx - cur_x; ey = gy - cur_y;
    z = 0; bearing = 0; rng = 0;
    if (ex != 0 || ey != 0) begin
      x = ex * 64; y = ey * 64;
      if (ex < 0) begin
        x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_ITER_DEF; i++) begin
        if (y > 0) begin
          nx = x + fshr(y, i); y = y - fshr(x, i); z = z + 32'(angle_tab[i]);
        end else begin
          nx = x - fshr(y, i); y = y + fshr(x, i); z = z - 32'(angle_tab[i]);
        end
        x = nx;
      end
      rng = (x * GAIN + 64'sd536870912) >>> 30;
      bearing = 16'((z + 32'd32768) >> 16);
    end
    diff = longint'($signed(16'(bearing - cur_head)));
    lim = longint'(lim_turn);
    if (diff > lim) diff = lim;
    if (diff < -lim) diff = -lim;
    stride = (rng < longint'(lim_speed)) ? rng : longint'(lim_speed);
    rotate_advance(16'(diff), stride);
    ex = gx - cur_x; ey = gy - cur_y;
    ax = ex < 0 ? -ex : ex;
    ay = ey < 0 ? -ey : ey;
    tol = longint'(tol_dist);
    if (ax > tol || ay > tol) return 1'b0;
    return (ax * ax + ay * ay <= tol * tol);
  endfunction

  always @(posedge clk) begin
    out_t exp_r, got;
    logic hit;
    int errs;
    errs = 0;
    if (rst) begin
      cur_x = 0; cur_y = 0; cur_head = 0; cur_dist = 0;
      lim_turn = MAX_TURN_RST; lim_speed = STEP_SPEED_RST; tol_dist = ARRIVE_TOL_RST;
      expected_pose.delete();
      fail_count <= 0; goal_count <= 0; reached_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MAX_TURN:   lim_turn = pwdata[14:0];
          REG_STEP_SPEED: lim_speed = pwdata[30:0];
          REG_ARRIVE_TOL: tol_dist = pwdata[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_pose.size() == 0) begin
          $error("result with no transaction outstanding");
          errs++;
        end else begin
          exp_r = expected_pose.pop_front();
          if (got.pos_x !== exp_r.pos_x) begin
            $error("pos_x exp %0d got %0d", exp_r.pos_x, got.pos_x);
            errs++;
          end
          if (got.pos_y !== exp_r.pos_y) begin
            $error("pos_y exp %0d got %0d", exp_r.pos_y, got.pos_y);
            errs++;
          end
          if (got.heading !== exp_r.heading) begin
            $error("heading exp %0d got %0d", exp_r.heading, got.heading);
            errs++;
          end
          if (got.travelled !== exp_r.travelled) begin
            $error("travelled exp %0d got %0d", exp_r.travelled, got.travelled);
            errs++;
          end
          if (got.reached !== exp_r.reached) begin
            $error("reached exp %0d got %0d", exp_r.reached, got.reached);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        hit = 1'b0;
        case (in_data.command)
          CMD_MOVE: rotate_advance(in_data.turn, longint'(in_data.advance));
          CMD_GOAL: begin
            hit = seek_goal(longint'(in_data.goal_x), longint'(in_data.goal_y));
            goal_count <= goal_count + 1;
            reached_count <= reached_count + hit;
          end
          CMD_RESET: begin
            cur_x = 0; cur_y = 0; cur_head = 0; cur_dist = 0;
          end
          default: ;
        endcase
        exp_r.pos_x = 32'(cur_x);
        exp_r.pos_y = 32'(cur_y);
        exp_r.heading = cur_head;
        exp_r.travelled = 48'(cur_dist);
        exp_r.reached = hit;
        expected_pose = {expected_pose, exp_r};
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_pose.size();
  end
endmodule

@@ tb/testbench.sv @@
module testbench;
  import upg_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  in_t in_data = '0;
  logic out_valid, in_ready, pready;
  out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending, goal_count, reached_count;
  int hold_off = 0, hold_req = 0, hold_seen = 0, sent = 0;
  bit stall_mode = 0;
  longint cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  unicycle_pose_go_to_goal dut (.*);
  pose_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** unicycle_pose_go_to_goal: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (stall_mode) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0 || in_valid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send(in_t item);
    in_valid <= 1; in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int r;
    r = $urandom_range(0, 99);
    it.turn = 16'($urandom);
    it.advance = ($urandom_range(0, 3) == 0) ? $urandom
                 : $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    it.goal_x = pick_coord();
    it.goal_y = pick_coord();
    it.command = r < 30 ? CMD_MOVE : r < 90 ? CMD_GOAL : r < 96 ? CMD_RESET : CMD_SPARE;
    return it;
  endfunction

  task automatic random_phase(int n);
    int burst, gap;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        send(rand_item());
        burst--; n--;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
  endtask

  initial begin
    in_t d;
    repeat (12) @(posedge clk);
    rst <= 0;
    stall_mode = 1;
    d = '0;
    d.command = CMD_GOAL; send(d);
    d.command = CMD_MOVE; d.turn = 16'sh4000; d.advance = 32'sh7FFF_FFFF; send(d);
    d.advance = 32'sh8000_0000; d.turn = 16'sh8000; send(d);
    d.turn = 16'sh7FFF; d.advance = 32'sh8000_0000; send(d);
    repeat (20) send(d);
    d.command = CMD_SPARE; send(d);
    d.command = CMD_GOAL; d.goal_x = 32'sh8000_0000; d.goal_y = 32'sh7FFF_FFFF; send(d);
    d.goal_x = 32'sh7FFF_FFFF; d.goal_y = 32'sh8000_0000; send(d);
    d.command = CMD_RESET; send(d);
    d.command = CMD_GOAL; d.goal_x = 32'sh0000_1000; d.goal_y = 0; send(d);
    d.command = CMD_MOVE; d.turn = 16'sh8001; d.advance = 32'sh0001_0000; send(d);
    in_valid <= 0;
    drain();

    cfg_write(REG_MAX_TURN, 32'd16384);
    cfg_write(REG_STEP_SPEED, 32'h7FFF_FFFF);
    cfg_write(REG_ARRIVE_TOL, 32'h7FFF_FFFF);
    random_phase(300);
    drain();

    cfg_write(REG_MAX_TURN, 32'd0);
    cfg_write(REG_STEP_SPEED, 32'd0);
    cfg_write(REG_ARRIVE_TOL, 32'd0);
    random_phase(150);
    drain();

    cfg_write(REG_MAX_TURN, 32'd8000);
    cfg_write(REG_STEP_SPEED, 32'd4 << 16);
    cfg_write(REG_ARRIVE_TOL, 32'd1 << 15);
    hold_req <= hold_req + 1;
    random_phase(100);
    drain();

    cfg_write(REG_MAX_TURN, 32'hFFFF_FFFF);
    cfg_write(REG_STEP_SPEED, 32'd2 << 16);
    cfg_write(REG_ARRIVE_TOL, 32'd6554);
    stall_mode = 0;
    random_phase(250);
    stall_mode = 1;
    random_phase(700);
    drain();

    $display("covered %0d transactions, %0d goal steps, %0d arrivals",
             sent, goal_count, reached_count);
    $display("register extremes, long output stall and drained pauses exercised");
    if (fail_count == 0) begin
      $display("** unicycle_pose_go_to_goal: PASSED **");
    end else begin
      $display("** unicycle_pose_go_to_goal: FAILED **");
    end
    $finish;
  end
endmodule
